@@ src/mqlb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the multi-queue linked buffer: command and result beat types,
// command and status codes, and the job record passed from front to back.
// No dependencies.
package mqlb_pkg;

  localparam int NumQueuesDef = 8;
  localparam int PoolDepthDef = 32;
  localparam int ListLimit    = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         queue_index;
    logic signed [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LIST
  } op_e;

  // Classified command as held in the queue between front and back.
  typedef struct packed {
    op_e                op;
    logic               qvalid;
    logic [2:0]         queue_index;
    logic signed [31:0] data;
  } job_t;

endpackage

@@ src/mqlb_front.sv @@
`timescale 1ns / 1ps
// Front end of the multi-queue linked buffer: accepts command beats,
// classifies them and holds them in a two-entry queue for the back end.
// Depends on mqlb_pkg.
module mqlb_front #(
  parameter int NUM_QUEUES = mqlb_pkg::NumQueuesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mqlb_pkg::cmd_t cmd_i,
  output logic          job_valid_o,
  output mqlb_pkg::job_t job_o,
  input  logic          job_pop_i
);

  mqlb_pkg::job_t job_d;
  mqlb_pkg::job_t buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           known_cmd, push, pop;

  always_comb begin
    known_cmd         = 1'b1;
    job_d.op          = mqlb_pkg::OP_INSERT;
    job_d.qvalid      = 32'(cmd_i.queue_index) < 32'(NUM_QUEUES);
    job_d.queue_index = cmd_i.queue_index;
    job_d.data        = cmd_i.data;
    unique case (cmd_i.command)
      mqlb_pkg::CMD_INSERT: job_d.op = mqlb_pkg::OP_INSERT;
      mqlb_pkg::CMD_REMOVE: job_d.op = mqlb_pkg::OP_REMOVE;
      mqlb_pkg::CMD_LIST:   job_d.op = mqlb_pkg::OP_LIST;
      default:              known_cmd = 1'b0;
    endcase
  end

  assign busy        = (cnt_q == 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = buf_q[rd_ptr_q];
  // An unused command code is taken off the port and then forgotten.
  assign push        = start && !busy && known_cmd;
  assign pop         = job_pop_i && job_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= job_d;
    end
  end

endmodule

@@ src/mqlb_back.sv @@
`timescale 1ns / 1ps
// Back end of the multi-queue linked buffer: the sequencer that carries out
// insert, remove and list, with the value, link and queue pointer memories.
// Depends on mqlb_pkg.
module mqlb_back #(
  parameter int NUM_QUEUES = mqlb_pkg::NumQueuesDef,
  parameter int POOL_DEPTH = mqlb_pkg::PoolDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  mqlb_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           result_valid_o,
  output mqlb_pkg::rsp_t rsp_o
);

  localparam int PW        = $clog2(POOL_DEPTH);
  localparam int CW        = $clog2(POOL_DEPTH + 1);
  localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int WalkLimit = (POOL_DEPTH < mqlb_pkg::ListLimit) ? POOL_DEPTH
                                                                : mqlb_pkg::ListLimit;
  localparam int KW        = $clog2(WalkLimit);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REMOVE,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
  } qent_t;

  // Memories
  logic signed [31:0] val_mem  [POOL_DEPTH];
  logic [PW-1:0]      link_mem [POOL_DEPTH];
  qent_t              qptr_mem [NUM_QUEUES];

  // Control state
  state_e             state_q, state_d;
  mqlb_pkg::job_t     job_q, job_d;
  logic [PW-1:0]      cur_q, cur_d;
  logic [KW-1:0]      k_q, k_d;
  logic [PW-1:0]      free_head_q, free_head_d;
  logic [CW-1:0]      free_count_q, free_count_d;
  logic [POOL_DEPTH-1:0] link_ok_q, link_ok_d;
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;
  logic               res_valid_q, res_valid_d;
  mqlb_pkg::rsp_t     rsp_q, rsp_d;

  // Read ports, registered
  logic signed [31:0] val_rd_q;
  logic [PW-1:0]      link_rd_q, link_addr_q;
  qent_t              qptr_rd_q;

  // Access controls
  logic [PW-1:0]      val_raddr, link_raddr, link_nxt;
  logic [QW-1:0]      q_raddr, qi;
  logic               val_we, link_we, qptr_we;
  logic [PW-1:0]      val_waddr, link_waddr, link_wdata;
  qent_t              qptr_wdata;
  logic               has, walk_end;
  logic [QW+2:0]      qi_ext, in_qi_ext;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] a);
    wrap_inc = (a == PW'(POOL_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign qi_ext    = (QW + 3)'(job_q.queue_index);
  assign in_qi_ext = (QW + 3)'(job_i.queue_index);
  assign qi        = qi_ext[QW-1:0];

  // A link never written still holds its reset chaining to the next entry.
  assign link_nxt  = link_ok_q[link_addr_q] ? link_rd_q : wrap_inc(link_addr_q);
  assign has       = job_q.qvalid && nonempty_q[qi];
  assign walk_end  = (cur_q == qptr_rd_q.tail) || (k_q == KW'(WalkLimit - 1));

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    cur_d        = cur_q;
    k_d          = k_q;
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    link_ok_d    = link_ok_q;
    nonempty_d   = nonempty_q;
    res_valid_d  = 1'b0;
    rsp_d        = rsp_q;
    job_pop_o    = 1'b0;
    q_raddr      = qi;
    val_raddr    = qptr_rd_q.head;
    link_raddr   = qptr_rd_q.head;
    val_we       = 1'b0;
    val_waddr    = free_head_q;
    link_we      = 1'b0;
    link_waddr   = qptr_rd_q.tail;
    link_wdata   = free_head_q;
    qptr_we      = 1'b0;
    qptr_wdata   = qptr_rd_q;

    unique case (state_q)
      ST_IDLE: begin
        q_raddr    = in_qi_ext[QW-1:0];
        link_raddr = free_head_q;
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          state_d   = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (job_q.op)
          mqlb_pkg::OP_INSERT: begin
            res_valid_d = 1'b1;
            rsp_d.value = '0;
            rsp_d.last  = 1'b1;
            state_d     = ST_IDLE;
            if (!job_q.qvalid || (free_count_q == '0)) begin
              rsp_d.status = mqlb_pkg::STATUS_FULL;
            end else begin
              rsp_d.status = mqlb_pkg::STATUS_OK;
              val_we       = 1'b1;
              if (nonempty_q[qi]) begin
                link_we                     = 1'b1;
                link_ok_d[qptr_rd_q.tail]   = 1'b1;
                qptr_wdata.head             = qptr_rd_q.head;
              end else begin
                qptr_wdata.head = free_head_q;
              end
              qptr_wdata.tail = free_head_q;
              qptr_we         = 1'b1;
              nonempty_d[qi]  = 1'b1;
              free_head_d     = link_nxt;
              free_count_d    = free_count_q - 1'b1;
            end
          end
          mqlb_pkg::OP_REMOVE, mqlb_pkg::OP_LIST: begin
            if (!has) begin
              res_valid_d  = 1'b1;
              rsp_d.value  = '0;
              rsp_d.status = mqlb_pkg::STATUS_EMPTY;
              rsp_d.last   = 1'b1;
              state_d      = ST_IDLE;
            end else begin
              cur_d   = qptr_rd_q.head;
              k_d     = '0;
              state_d = (job_q.op == mqlb_pkg::OP_REMOVE) ? ST_REMOVE : ST_WALK;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_REMOVE: begin
        res_valid_d  = 1'b1;
        rsp_d.value  = val_rd_q;
        rsp_d.status = mqlb_pkg::STATUS_OK;
        rsp_d.last   = 1'b1;
        if (cur_q == qptr_rd_q.tail) begin
          nonempty_d[qi] = 1'b0;
        end else begin
          qptr_wdata.head = link_nxt;
          qptr_we         = 1'b1;
        end
        // The freed entry goes back on the front of the free list.
        link_we          = 1'b1;
        link_waddr       = cur_q;
        link_wdata       = free_head_q;
        link_ok_d[cur_q] = 1'b1;
        free_head_d      = cur_q;
        if (free_count_q < CW'(POOL_DEPTH)) begin
          free_count_d = free_count_q + 1'b1;
        end
        state_d = ST_IDLE;
      end

      ST_WALK: begin
        res_valid_d  = 1'b1;
        rsp_d.value  = val_rd_q;
        rsp_d.status = mqlb_pkg::STATUS_OK;
        rsp_d.last   = walk_end;
        val_raddr    = link_nxt;
        link_raddr   = link_nxt;
        if (walk_end) begin
          state_d = ST_IDLE;
        end else begin
          cur_d = link_nxt;
          k_d   = k_q + 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      job_q        <= '0;
      cur_q        <= '0;
      k_q          <= '0;
      free_head_q  <= '0;
      free_count_q <= CW'(POOL_DEPTH);
      link_ok_q    <= '0;
      nonempty_q   <= '0;
      res_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      state_q      <= state_d;
      job_q        <= job_d;
      cur_q        <= cur_d;
      k_q          <= k_d;
      free_head_q  <= free_head_d;
      free_count_q <= free_count_d;
      link_ok_q    <= link_ok_d;
      nonempty_q   <= nonempty_d;
      res_valid_q  <= res_valid_d;
      rsp_q        <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= job_q.data;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (qptr_we) begin
      qptr_mem[qi] <= qptr_wdata;
    end
    val_rd_q    <= val_mem[val_raddr];
    link_rd_q   <= link_mem[link_raddr];
    link_addr_q <= link_raddr;
    qptr_rd_q   <= qptr_mem[q_raddr];
  end

  assign result_valid_o = res_valid_q;
  assign rsp_o          = rsp_q;

endmodule

@@ src/multi_queue_linked_buffer_core.sv @@
`timescale 1ns / 1ps
// Multi-queue linked buffer: NUM_QUEUES FIFO queues sharing a pool of
// POOL_DEPTH linked entries. Uses mqlb_pkg, mqlb_front and mqlb_back.
//
// Commands enter on cmd_i and are taken at a clock edge where start is high
// and busy is low. Each beat is insert, remove head or list. Results leave on
// rsp_o for one cycle each, marked by result_valid_o; the receiver cannot
// hold them off, and the last beat that a command causes has last set.
// A two-entry command queue sits between the front end and the sequencer,
// so busy rises only when two commands are waiting behind the one in work.
// An accepted command passes the command queue, the sequencer's job register
// and the result register before its strobe; on a non-empty queue a remove
// and the first list beat also pass the remove or walk state, then a list
// gives one beat per cycle. The single registered read port of the memories
// sets these steps: idle, exec, then remove or one walk state per list entry.
// Unused command codes are accepted and give no results.
// After reset all queues are empty and every entry is on the free list; the
// link memory needs no clearing pass, as per-entry flags stand in for it.
module multi_queue_linked_buffer_core #(
  parameter int NUM_QUEUES = mqlb_pkg::NumQueuesDef,
  parameter int POOL_DEPTH = mqlb_pkg::PoolDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mqlb_pkg::cmd_t cmd_i,
  output logic           result_valid_o,
  output mqlb_pkg::rsp_t rsp_o
);

  logic           job_valid;
  logic           job_pop;
  mqlb_pkg::job_t job;

  mqlb_front #(
    .NUM_QUEUES(NUM_QUEUES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_pop_i  (job_pop)
  );

  mqlb_back #(
    .NUM_QUEUES(NUM_QUEUES),
    .POOL_DEPTH(POOL_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_pop_o     (job_pop),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_queue_linked_buffer_core: drives insert, remove and
// list commands and checks each result beat against a scoreboard that keeps its own
// copy of the queues and the free list. Depends on mqlb_pkg and the core.
module tb_top;

  localparam int NumQueues = mqlb_pkg::NumQueuesDef;
  localparam int PoolDepth = mqlb_pkg::PoolDepthDef;
  localparam logic [1:0] CmdUnused = 2'd3;

  class mqlb_scoreboard;
    logic signed [31:0] slot_value[PoolDepth];
    int unsigned        slot_link[PoolDepth];
    int unsigned        head_of[NumQueues];
    int unsigned        tail_of[NumQueues];
    bit                 occupied[NumQueues];
    int unsigned        free_head;
    int unsigned        free_count;
    mqlb_pkg::rsp_t     expected_beats[$];
    int errors, n_insert, n_remove, n_list, n_ignored, n_beats, n_dropped, longest_list;

    function new();
      for (int i = 0; i < PoolDepth; i++) begin
        slot_value[i] = '0;
        slot_link[i]  = (i + 1) % PoolDepth;
      end
      for (int i = 0; i < NumQueues; i++) begin
        head_of[i]  = 0;
        tail_of[i]  = 0;
        occupied[i] = 1'b0;
      end
      free_head  = 0;
      free_count = PoolDepth;
    endfunction

    function void push_beat(logic signed [31:0] v, logic [1:0] s, logic l);
      mqlb_pkg::rsp_t b;
      b.value  = v;
      b.status = s;
      b.last   = l;
      expected_beats.push_back(b);
    endfunction

    // Works out the beats that one accepted command causes and updates the pool.
    function void note_command(mqlb_pkg::cmd_t c);
      int unsigned q, idx, walked;
      bit known, stop;
      q     = c.queue_index;
      known = q < NumQueues;
      case (c.command)
        mqlb_pkg::CMD_INSERT: begin
          n_insert++;
          if (!known || free_count == 0) begin
            n_dropped++;
            push_beat('0, mqlb_pkg::STATUS_FULL, 1'b1);
          end else begin
            idx        = free_head;
            free_head  = slot_link[idx];
            free_count--;
            slot_value[idx] = c.data;
            if (occupied[q]) begin
              slot_link[tail_of[q]] = idx;
            end else begin
              head_of[q] = idx;
            end
            tail_of[q]  = idx;
            occupied[q] = 1'b1;
            push_beat('0, mqlb_pkg::STATUS_OK, 1'b1);
          end
        end
        mqlb_pkg::CMD_REMOVE: begin
          n_remove++;
          if (!known || !occupied[q]) begin
            push_beat('0, mqlb_pkg::STATUS_EMPTY, 1'b1);
          end else begin
            idx = head_of[q];
            if (idx == tail_of[q]) begin
              occupied[q] = 1'b0;
            end else begin
              head_of[q] = slot_link[idx];
            end
            slot_link[idx] = free_head;
            free_head      = idx;
            if (free_count < PoolDepth) free_count++;
            push_beat(slot_value[idx], mqlb_pkg::STATUS_OK, 1'b1);
          end
        end
        mqlb_pkg::CMD_LIST: begin
          n_list++;
          if (!known || !occupied[q]) begin
            push_beat('0, mqlb_pkg::STATUS_EMPTY, 1'b1);
          end else begin
            idx    = head_of[q];
            walked = 0;
            stop   = 1'b0;
            // The walk is cut short once the list limit is reached.
            while (!stop) begin
              walked++;
              stop = (idx == tail_of[q]) || (walked >= mqlb_pkg::ListLimit) ||
                     (walked >= PoolDepth);
              push_beat(slot_value[idx], mqlb_pkg::STATUS_OK, stop);
              idx = slot_link[idx];
            end
            if (walked > longest_list) longest_list = walked;
          end
        end
        default: begin
          n_ignored++;
        end
      endcase
    endfunction

    function void check_result(mqlb_pkg::rsp_t got);
      mqlb_pkg::rsp_t want;
      n_beats++;
      if (expected_beats.size() == 0) begin
        errors++;
        $error("result beat with none expected: value %0d status %0d last %0d",
               got.value, got.status, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got.value !== want.value) begin
        errors++;
        $error("value: expected %0d, got %0d", want.value, got.value);
      end
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, got.status);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %0d, got %0d", want.last, got.last);
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start;
  logic           busy;
  mqlb_pkg::cmd_t cmd_i;
  logic           result_valid_o;
  mqlb_pkg::rsp_t rsp_o;

  mqlb_scoreboard sb = new();

  multi_queue_linked_buffer_core #(
    .NUM_QUEUES(NumQueues),
    .POOL_DEPTH(PoolDepth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Commands and result beats are both sampled on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_command(cmd_i);
      if (result_valid_o) sb.check_result(rsp_o);
    end
  end

  task automatic send_cmd(logic [1:0] op, int q, logic [31:0] d);
    @(negedge clk_i);
    start             <= 1'b1;
    cmd_i.command     <= op;
    cmd_i.queue_index <= q[2:0];
    cmd_i.data        <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle(int n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Holds the sender off until every expected beat is back, then waits on with
  // start low so that stray beats would show.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (mqlb_pkg::ListLimit + 8) @(posedge clk_i);
  endtask

  task automatic random_phase(int items, int w_ins, int w_rem, int w_lst, int focus, bit gaps);
    int sent, roll, q;
    logic [1:0] op;
    logic [31:0] d;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 99) < 3) begin
        op = CmdUnused;
      end else begin
        roll = $urandom_range(0, w_ins + w_rem + w_lst - 1);
        if (roll < w_ins) op = mqlb_pkg::CMD_INSERT;
        else if (roll < w_ins + w_rem) op = mqlb_pkg::CMD_REMOVE;
        else op = mqlb_pkg::CMD_LIST;
      end
      if (focus >= 0 && $urandom_range(0, 3) != 0) q = focus;
      else q = $urandom_range(0, 7);
      case ($urandom_range(0, 7))
        0: d = 32'h8000_0000;
        1: d = 32'h7fff_ffff;
        2: d = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
        default: d = $urandom;
      endcase
      send_cmd(op, q, d);
      if (op != CmdUnused) sent++;
      if (gaps && $urandom_range(0, 3) == 0) idle($urandom_range(1, 10));
    end
  endtask

  initial begin
    int focus;
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty queues, extreme values, a short list, an unused code and emptying again.
    send_cmd(mqlb_pkg::CMD_LIST, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 0, 32'hffff_ffff);
    send_cmd(mqlb_pkg::CMD_REMOVE, 7, 32'h0);
    send_cmd(mqlb_pkg::CMD_INSERT, 0, 32'h8000_0000);
    send_cmd(mqlb_pkg::CMD_INSERT, 0, 32'h7fff_ffff);
    send_cmd(mqlb_pkg::CMD_INSERT, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_INSERT, 0, 32'hffff_ffff);
    send_cmd(mqlb_pkg::CMD_LIST, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_INSERT, 7, 32'h5a5a_a5a5);
    send_cmd(mqlb_pkg::CMD_INSERT, 7, 32'ha5a5_5a5a);
    send_cmd(mqlb_pkg::CMD_LIST, 7, 32'h0);
    send_cmd(CmdUnused, 5, 32'h1234_5678);
    send_cmd(mqlb_pkg::CMD_REMOVE, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_LIST, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_LIST, 0, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 7, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 7, 32'h0);
    send_cmd(mqlb_pkg::CMD_REMOVE, 7, 32'h0);
    drain();

    random_phase(80, 4, 3, 2, -1, 1'b1);
    // Piling inserts onto one queue fills the pool and gives full-length lists.
    focus = $urandom_range(0, 7);
    random_phase(60, 12, 1, 3, focus, 1'b1);
    drain();
    random_phase(70, 1, 8, 2, focus, 1'b1);
    random_phase(80, 3, 3, 2, -1, 1'b0);
    drain();

    $display("Covered %0d inserts (%0d dropped on a full pool), %0d removes,",
             sb.n_insert, sb.n_dropped, sb.n_remove);
    $display("%0d lists and %0d unused codes; checked %0d result beats, longest list %0d.",
             sb.n_list, sb.n_ignored, sb.n_beats, sb.longest_list);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
src/mqlb_pkg.sv
src/mqlb_front.sv
src/mqlb_back.sv
src/multi_queue_linked_buffer_core.sv
test/tb_top.sv
